/* hw/rtl/lph_pkg.sv */
// shared types and constants for the linear-probing hash table
// no dependencies

package lph_pkg;

    localparam int KEY_W    = 31;
    localparam int VAL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic    clr_write;
        logic    load;
        logic    mod_step;
        logic    probe_start;
        logic    probe_step;
        logic    ins_write;
        logic    result_valid;
        t_status result_code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_last;
        t_op  op;
        logic slot_empty;
        logic key_match;
        logic lap_last;
    } t_stat;

endpackage

/* hw/rtl/lph_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module lph_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/lph_ctrl.sv */
// controller state machine: clearing pass, key reduction, probe decisions
// depends on lph_pkg

module lph_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lph_pkg::t_stat i_stat,
    output lph_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_HOME,
        S_PROBE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    lph_pkg::t_cmd cmd;

    always_comb begin
        n_state          = r_state;
        cmd              = '0;
        cmd.result_code  = lph_pkg::ST_INSERTED;
        case (r_state)
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start && !r_busy) begin
                    cmd.load = 1'b1;
                    n_state  = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                cmd.probe_start = 1'b1;
                n_state         = S_PROBE;
            end
            S_PROBE: begin
                if (i_stat.op == lph_pkg::OP_INSERT) begin
                    if (i_stat.slot_empty) begin
                        cmd.ins_write    = 1'b1;
                        cmd.result_valid = 1'b1;
                        cmd.result_code  = lph_pkg::ST_INSERTED;
                        n_state          = S_IDLE;
                    end else if (i_stat.lap_last) begin
                        cmd.result_valid = 1'b1;
                        cmd.result_code  = lph_pkg::ST_FULL;
                        n_state          = S_IDLE;
                    end else begin
                        cmd.probe_step = 1'b1;
                    end
                end else begin
                    if (i_stat.slot_empty) begin
                        cmd.result_valid = 1'b1;
                        cmd.result_code  = lph_pkg::ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end else if (i_stat.key_match) begin
                        cmd.result_valid = 1'b1;
                        cmd.result_code  = lph_pkg::ST_FOUND;
                        n_state          = S_IDLE;
                    end else if (i_stat.lap_last) begin
                        cmd.result_valid = 1'b1;
                        cmd.result_code  = lph_pkg::ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end else begin
                        cmd.probe_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

/* hw/rtl/lph_dp.sv */
// datapath: request registers, reciprocal key modulo, probe index, slot ram, result registers
// depends on lph_pkg and lph_ram

module lph_dp #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lph_pkg::t_cmd               i_cmd,
    input  logic                        i_operation,
    input  logic [lph_pkg::KEY_W-1:0]   i_key,
    input  logic [lph_pkg::VAL_W-1:0]   i_value,
    output lph_pkg::t_stat              o_stat,
    output logic                        o_valid,
    output logic [lph_pkg::STATUS_W-1:0] o_status,
    output logic [lph_pkg::SLOT_W-1:0]  o_slot,
    output logic [lph_pkg::VAL_W-1:0]   o_found_value
);

    localparam int KEY_W   = lph_pkg::KEY_W;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int ENTRY_W = 1 + lph_pkg::KEY_W + lph_pkg::VAL_W;
    localparam int EXT_W   = (IDX_W > lph_pkg::SLOT_W) ? IDX_W : lph_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [KEY_W-1:0] SLOTS_K  = KEY_W'(SLOTS);
    localparam logic [KEY_W-1:0] RECIP    = KEY_W'((64'd1 << KEY_W) / SLOTS);

    logic                      r_op;
    logic [lph_pkg::KEY_W-1:0] r_key;
    logic [lph_pkg::VAL_W-1:0] r_value;
    logic [1:0]                r_mod_cnt;
    logic [2*KEY_W-1:0]        r_prod;
    logic [KEY_W-1:0]          r_qd;
    logic [IDX_W-1:0]          r_rem;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_clr_idx;
    logic                      r_valid;
    logic [lph_pkg::STATUS_W-1:0] r_status;
    logic [lph_pkg::SLOT_W-1:0] r_slot;
    logic [lph_pkg::VAL_W-1:0] r_found_value;

    logic [KEY_W-1:0]          quot;
    logic [KEY_W-1:0]          diff;
    logic [IDX_W-1:0]          n_rem;
    logic [IDX_W-1:0]          idx_next;
    logic [EXT_W-1:0]          idx_ext;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENTRY_W-1:0]        wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [ENTRY_W-1:0]        rd_data;
    logic                      rd_used;
    logic [lph_pkg::KEY_W-1:0] rd_key;
    logic [lph_pkg::VAL_W-1:0] rd_value;
    logic                      hit;

    // reciprocal quotient is exact or one short, so one subtract corrects it
    assign quot  = r_prod[2*KEY_W-1:KEY_W];
    assign diff  = r_key - r_qd;
    assign n_rem = (diff >= SLOTS_K) ? IDX_W'(diff - SLOTS_K) : diff[IDX_W-1:0];

    assign idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign idx_ext  = EXT_W'(r_idx);

    assign wr_en   = i_cmd.clr_write | i_cmd.ins_write;
    assign wr_addr = i_cmd.clr_write ? r_clr_idx : r_idx;
    assign wr_data = i_cmd.clr_write ? '0 : {1'b1, r_key, r_value};
    assign rd_addr = i_cmd.probe_start ? r_rem : idx_next;

    lph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_used  = rd_data[ENTRY_W-1];
    assign rd_key   = rd_data[ENTRY_W-2 -: lph_pkg::KEY_W];
    assign rd_value = rd_data[lph_pkg::VAL_W-1:0];
    assign hit      = rd_used && (rd_key == r_key);

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = (r_clr_idx == LAST_IDX);
        o_stat.mod_last   = (r_mod_cnt == 2'd0);
        o_stat.op         = lph_pkg::t_op'(r_op);
        o_stat.slot_empty = !rd_used;
        o_stat.key_match  = hit;
        o_stat.lap_last   = (r_cnt == LAST_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cmd.clr_write) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            r_valid <= i_cmd.result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_key     <= i_key;
            r_value   <= i_value;
            r_rem     <= '0;
            r_mod_cnt <= 2'd2;
        end
        if (i_cmd.mod_step) begin
            r_prod    <= {{KEY_W{1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP};
            r_qd      <= quot * SLOTS_K;
            r_rem     <= n_rem;
            r_mod_cnt <= r_mod_cnt - 1'b1;
        end
        if (i_cmd.probe_start) begin
            r_idx <= r_rem;
            r_cnt <= '0;
        end
        if (i_cmd.probe_step) begin
            r_idx <= idx_next;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.result_valid) begin
            r_status <= i_cmd.result_code;
            if (i_cmd.result_code == lph_pkg::ST_INSERTED ||
                i_cmd.result_code == lph_pkg::ST_FOUND) begin
                r_slot <= idx_ext[lph_pkg::SLOT_W-1:0];
            end else begin
                r_slot <= '0;
            end
            if (i_cmd.result_code == lph_pkg::ST_FOUND) begin
                r_found_value <= rd_value;
            end else begin
                r_found_value <= '0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_found_value = r_found_value;

endmodule

/* hw/rtl/linear_probe_hash_table.sv */
// top level of the linear-probing hash table: controller plus datapath
// depends on lph_pkg, lph_ctrl, lph_dp
//
// channel   direction  handshake           payload
// request   in         start, busy         i_operation, i_key, i_value
// result    out        o_valid (strobe)    o_status, o_slot, o_found_value
//
// the result strobe follows the key modulo SLOTS by reciprocal multiply (product, then
// quotient times SLOTS, then the remainder with one corrective subtract), the home-slot
// ram read, then 1 to SLOTS probed slots at one per cycle on the ram read port
// busy falls with the strobe, so the next request can be taken at the edge ending it
// after reset a clearing pass empties the slot ram, busy held high
// results cannot be stalled

module linear_probe_hash_table #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [lph_pkg::KEY_W-1:0]    i_key,
    input  logic [lph_pkg::VAL_W-1:0]    i_value,
    output logic                         o_valid,
    output logic [lph_pkg::STATUS_W-1:0] o_status,
    output logic [lph_pkg::SLOT_W-1:0]   o_slot,
    output logic [lph_pkg::VAL_W-1:0]    o_found_value
);

    lph_pkg::t_cmd  cmd;
    lph_pkg::t_stat stat;

    lph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lph_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_found_value (o_found_value)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after accepted request");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy still high with result strobe");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == lph_pkg::ST_FULL || o_status == lph_pkg::ST_NOT_FOUND)
        |-> (o_slot == '0) && (o_found_value == '0))
        else $error("nonzero fields on full or not found");

    a_insert_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == lph_pkg::ST_INSERTED) |-> (o_found_value == '0))
        else $error("nonzero value on insert result");
`endif

endmodule
